>>> sv/icv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_pkg
// Shared types and constants of the 2d convolution core.
// ----------------------------------------------------------------------------
package icv_pkg;

  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int MAX_KERNEL_DEF   = 5;
  localparam int MAX_HEIGHT       = 4096;
  localparam int WEIGHT_FRAC_BITS = 12;
  localparam int CH               = 4;
  localparam int SUM_W            = 40;
  localparam int TOT_W            = 24;
  localparam int ROW_W            = $clog2(MAX_HEIGHT + 1);
  localparam int CFG_W            = 13;
  localparam int CFG_IDX_W        = 3;

  localparam logic [1:0] REQ_TAP   = 2'd0;
  localparam logic [1:0] REQ_PIX   = 2'd1;
  localparam logic [1:0] REQ_DRAIN = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_NORM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IW   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KW   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KH   = 3'd4;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [2:0]         tap_row;
    logic [2:0]         tap_col;
    logic signed [15:0] weight_red;
    logic signed [15:0] weight_green;
    logic signed [15:0] weight_blue;
    logic signed [15:0] weight_alpha;
    logic [15:0]        pix_red;
    logic [15:0]        pix_green;
    logic [15:0]        pix_blue;
    logic [15:0]        pix_alpha;
  } in_req_t;

  typedef struct packed {
    logic [15:0] out_red;
    logic [15:0] out_green;
    logic [15:0] out_blue;
    logic [15:0] out_alpha;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic        last_of_frame;
  } out_res_t;

  typedef struct packed {
    logic clr;
    logic vld;
    logic inb;
  } mac_ctrl_t;

endpackage

>>> sv/icv_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_mac
// Four-lane multiply-accumulate of tap weights and window pixels.
// ----------------------------------------------------------------------------
module icv_mac (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  icv_pkg::mac_ctrl_t                          ctrl_i,
  input  logic [63:0]                                 tap_i,
  input  logic [63:0]                                 pix_i,
  output logic [icv_pkg::CH-1:0][icv_pkg::SUM_W-1:0]  sum_o,
  output logic [icv_pkg::CH-1:0][icv_pkg::TOT_W-1:0]  tot_o
);

  logic                                       v_q;
  logic [icv_pkg::CH-1:0][32:0]               prod_q;
  logic [icv_pkg::CH-1:0][32:0]               prod_d;
  logic [icv_pkg::CH-1:0][15:0]               wgt_q;
  logic [icv_pkg::CH-1:0][icv_pkg::SUM_W-1:0] sum_q;
  logic [icv_pkg::CH-1:0][icv_pkg::TOT_W-1:0] tot_q;

  always_comb begin
    for (int c = 0; c < icv_pkg::CH; c++) begin
      logic [32:0] a;
      logic [32:0] b;
      a = {{17{tap_i[(icv_pkg::CH-1-c)*16+15]}}, tap_i[(icv_pkg::CH-1-c)*16 +: 16]};
      b = {17'd0, pix_i[(icv_pkg::CH-1-c)*16 +: 16]};
      // low bits of the product are sign-correct
      prod_d[c] = ctrl_i.inb ? a * b : 33'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= ctrl_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.vld) begin
      prod_q <= prod_d;
      for (int c = 0; c < icv_pkg::CH; c++) begin
        wgt_q[c] <= tap_i[(icv_pkg::CH-1-c)*16 +: 16];
      end
    end
    if (ctrl_i.clr) begin
      sum_q <= '0;
      tot_q <= '0;
    end else if (v_q) begin
      for (int c = 0; c < icv_pkg::CH; c++) begin
        sum_q[c] <= sum_q[c] + {{(icv_pkg::SUM_W-33){prod_q[c][32]}}, prod_q[c]};
        tot_q[c] <= tot_q[c] + {{(icv_pkg::TOT_W-16){wgt_q[c][15]}}, wgt_q[c]};
      end
    end
  end

  assign sum_o = sum_q;
  assign tot_o = tot_q;

endmodule

>>> sv/icv_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icv_div
// Four-lane restoring divider with shift path and saturation to 16 bits.
// ----------------------------------------------------------------------------
module icv_div (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        start_i,
  input  logic                                        norm_i,
  input  logic [icv_pkg::CH-1:0][icv_pkg::SUM_W-1:0]  sum_i,
  input  logic [icv_pkg::CH-1:0][icv_pkg::TOT_W-1:0]  tot_i,
  output logic                                        done_o,
  output logic [icv_pkg::CH-1:0][15:0]                res_o
);

  localparam int CNT_W = $clog2(icv_pkg::SUM_W + 1);

  logic                                       busy_q;
  logic                                       done_q;
  logic [CNT_W-1:0]                           cnt_q;
  logic                                       norm_q;
  logic [icv_pkg::CH-1:0]                     zero_q;
  logic [icv_pkg::CH-1:0][15:0]               shres_q;
  logic [icv_pkg::CH-1:0][icv_pkg::SUM_W-1:0] dvd_q;
  logic [icv_pkg::CH-1:0][icv_pkg::TOT_W-1:0] rem_q;
  logic [icv_pkg::CH-1:0][icv_pkg::TOT_W-1:0] mt_q;
  logic [icv_pkg::CH-1:0][15:0]               res_q;

  logic [icv_pkg::CH-1:0][icv_pkg::SUM_W-1:0] dvd_d;
  logic [icv_pkg::CH-1:0][icv_pkg::TOT_W-1:0] rem_d;
  logic [icv_pkg::CH-1:0][15:0]               fin_d;
  logic [icv_pkg::CH-1:0]                     zero_d;
  logic [icv_pkg::CH-1:0][15:0]               shres_d;
  logic [icv_pkg::CH-1:0][icv_pkg::SUM_W-1:0] ms_d;
  logic [icv_pkg::CH-1:0][icv_pkg::TOT_W-1:0] mt_d;

  always_comb begin
    for (int c = 0; c < icv_pkg::CH; c++) begin
      logic                        sneg;
      logic                        tneg;
      logic [icv_pkg::SUM_W-1:0]   shv;
      logic [icv_pkg::TOT_W:0]     rsh;
      logic                        ge;
      sneg = sum_i[c][icv_pkg::SUM_W-1];
      tneg = tot_i[c][icv_pkg::TOT_W-1];
      ms_d[c] = sneg ? (~sum_i[c] + 1'b1) : sum_i[c];
      mt_d[c] = tneg ? (~tot_i[c] + 1'b1) : tot_i[c];
      zero_d[c] = norm_i ? ((sum_i[c] == '0) || (sneg != tneg)) : sneg;
      shv = sum_i[c] >> icv_pkg::WEIGHT_FRAC_BITS;
      shres_d[c] = (|shv[icv_pkg::SUM_W-1:16]) ? 16'hFFFF : shv[15:0];
      // one quotient bit per cycle
      rsh = {rem_q[c], dvd_q[c][icv_pkg::SUM_W-1]};
      ge  = rsh >= {1'b0, mt_q[c]};
      rem_d[c] = icv_pkg::TOT_W'(ge ? (rsh - {1'b0, mt_q[c]}) : rsh);
      dvd_d[c] = {dvd_q[c][icv_pkg::SUM_W-2:0], ge};
      if (zero_q[c]) begin
        fin_d[c] = 16'd0;
      end else if (norm_q) begin
        fin_d[c] = (|dvd_d[c][icv_pkg::SUM_W-1:16]) ? 16'hFFFF : dvd_d[c][15:0];
      end else begin
        fin_d[c] = shres_q[c];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(icv_pkg::SUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      norm_q  <= norm_i;
      zero_q  <= zero_d;
      shres_q <= shres_d;
      dvd_q   <= ms_d;
      mt_q    <= mt_d;
      rem_q   <= '0;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
      if (cnt_q == CNT_W'(1)) begin
        res_q <= fin_d;
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> sv/image_convolution_2d_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_convolution_2d_core
// Streaming 2d convolution of four-channel pixels with zero padding.
//
//  channel | signals                              | role
//  --------+--------------------------------------+-----------------------
//  in      | in_valid_i, in_ready_o, in_req_i     | taps, pixels, drains
//  out     | out_valid_o, out_ready_i, out_res_o  | filtered pixels
//  cfg     | cfg_we_i, cfg_idx_i, cfg_wdata_i     | register writes
//
// a request with a result sweeps all kw*kh taps, one tap per cycle, from the
// tap and line memories, then goes through the 40-step divider. one request
// is worked on at a time.
// reset clears the counters and sets the size registers to 640x480 with a 3x3 kernel; memory contents start undefined.
// a finished result waits in the output register while the next request
// is taken; a new result is held back until that register is free.
// ----------------------------------------------------------------------------
module image_convolution_2d_core #(
  parameter int MAX_WIDTH  = icv_pkg::MAX_WIDTH_DEF,
  parameter int MAX_KERNEL = icv_pkg::MAX_KERNEL_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  icv_pkg::in_req_t                in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output icv_pkg::out_res_t               out_res_o,
  input  logic                            cfg_we_i,
  input  logic [icv_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [icv_pkg::CFG_W-1:0]       cfg_wdata_i
);

  localparam int SLOTS = MAX_KERNEL + 1;
  localparam int CW    = $clog2(MAX_WIDTH + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int KCW   = $clog2(MAX_KERNEL + 1);
  localparam int TAPS  = MAX_KERNEL * MAX_KERNEL;
  localparam int TA    = $clog2(TAPS);
  localparam int SW    = $clog2(SLOTS);
  localparam int STW   = $clog2(3 * SLOTS);
  localparam int LDEP  = SLOTS * MAX_WIDTH;
  localparam int LA    = $clog2(LDEP);
  localparam int RW    = icv_pkg::ROW_W;
  localparam int PW    = RW + CW;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SWEEP, ST_FLUSH, ST_DIV, ST_OUT
  } state_e;

  state_e state_q;

  logic        norm_q;
  logic [10:0] iw_q;
  logic [12:0] ih_q;
  logic [2:0]  kw_q;
  logic [2:0]  kh_q;

  logic [CW-1:0]  w;
  logic [RW-1:0]  h;
  logic [KCW-1:0] kw;
  logic [KCW-1:0] kh;
  logic [KCW-1:0] half_w;
  logic [KCW-1:0] half_h;
  logic [PW-1:0]  lag;

  logic [RW-1:0] in_row_q;
  logic [CW-1:0] in_col_q;
  logic [SW-1:0] in_slot_q;
  logic [PW-1:0] pix_q;
  logic [RW-1:0] orow_q;
  logic [CW-1:0] ocol_q;
  logic [SW-1:0] oslot_q;

  logic [RW-1:0]  ei_q;
  logic [CW-1:0]  ej_q;
  logic [SW-1:0]  eslot_q;
  logic           elast_q;
  logic [KCW-1:0] ki_q;
  logic [KCW-1:0] kj_q;
  logic [1:0]     flush_q;
  logic           rd_v_q;
  logic           rd_inb_q;
  logic           out_valid_q;
  icv_pkg::out_res_t out_q;

  logic [63:0] line_mem [LDEP];
  logic [63:0] tap_mem [TAPS];
  logic [63:0] line_rd_q;
  logic [63:0] tap_rd_q;

  logic           acc;
  logic           is_tap;
  logic           pix_ok;
  logic           emit;
  logic           last;
  logic           tap_ok;
  logic [RW:0]    ys;
  logic [CW:0]    xs;
  logic           inb;
  logic [STW-1:0] st;
  logic [SW-1:0]  slot_rd;
  logic [LA-1:0]  line_ra;
  logic [LA-1:0]  line_wa;
  logic [TA-1:0]  tap_ra;
  logic [TA-1:0]  tap_wa;
  logic [63:0]    pix_word;
  logic [63:0]    tap_word;
  logic           div_start;
  logic           div_done;
  logic           div_norm;

  icv_pkg::mac_ctrl_t                         mac_ctrl;
  logic [icv_pkg::CH-1:0][icv_pkg::SUM_W-1:0] sums;
  logic [icv_pkg::CH-1:0][icv_pkg::TOT_W-1:0] tots;
  logic [icv_pkg::CH-1:0][15:0]               res;

  // zero acts as one, oversize acts as the maximum
  always_comb begin
    w  = (iw_q == '0) ? CW'(1) :
         ((32'(iw_q) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(iw_q));
    h  = (ih_q == '0) ? RW'(1) :
         ((32'(ih_q) > icv_pkg::MAX_HEIGHT) ? RW'(icv_pkg::MAX_HEIGHT) : RW'(ih_q));
    kw = (kw_q == '0) ? KCW'(1) :
         ((32'(kw_q) > MAX_KERNEL) ? KCW'(MAX_KERNEL) : KCW'(kw_q));
    kh = (kh_q == '0) ? KCW'(1) :
         ((32'(kh_q) > MAX_KERNEL) ? KCW'(MAX_KERNEL) : KCW'(kh_q));
    half_w = kw >> 1;
    half_h = kh >> 1;
    lag = PW'(PW'(kh - KCW'(1) - half_h) * PW'(w) + PW'(kw - KCW'(1) - half_w));
  end

  assign acc    = in_valid_i && in_ready_o;
  assign is_tap = in_req_i.req_type == icv_pkg::REQ_TAP;
  assign pix_ok = (in_req_i.req_type == icv_pkg::REQ_PIX) && (in_row_q < h) && (in_col_q < w);
  assign emit   = pix_ok ? (pix_q >= lag) : (!is_tap && (in_row_q >= h) && (orow_q < h));
  assign last   = (orow_q == h - RW'(1)) && (ocol_q == w - CW'(1));
  assign tap_ok = (32'(in_req_i.tap_row) < MAX_KERNEL) && (32'(in_req_i.tap_col) < MAX_KERNEL);

  assign pix_word = {in_req_i.pix_red, in_req_i.pix_green, in_req_i.pix_blue,
                     in_req_i.pix_alpha};
  assign tap_word = {in_req_i.weight_red, in_req_i.weight_green, in_req_i.weight_blue,
                     in_req_i.weight_alpha};

  // window position of the current tap, offset by half the kernel
  always_comb begin
    ys  = (RW+1)'(ei_q) + (RW+1)'(ki_q);
    xs  = (CW+1)'(ej_q) + (CW+1)'(kj_q);
    inb = (ys >= (RW+1)'(half_h)) && ((ys - (RW+1)'(half_h)) < (RW+1)'(h)) &&
          (xs >= (CW+1)'(half_w)) && ((xs - (CW+1)'(half_w)) < (CW+1)'(w));
    st  = STW'(STW'(eslot_q) + STW'(ki_q) + STW'(SLOTS) - STW'(half_h));
    if (st >= STW'(2 * SLOTS)) begin
      slot_rd = SW'(st - STW'(2 * SLOTS));
    end else if (st >= STW'(SLOTS)) begin
      slot_rd = SW'(st - STW'(SLOTS));
    end else begin
      slot_rd = SW'(st);
    end
    line_ra = LA'(LA'(slot_rd) * LA'(MAX_WIDTH) + LA'(XW'(xs - (CW+1)'(half_w))));
    tap_ra  = TA'(TA'(ki_q) * TA'(MAX_KERNEL) + TA'(kj_q));
    line_wa = LA'(LA'(in_slot_q) * LA'(MAX_WIDTH) + LA'(XW'(in_col_q)));
    tap_wa  = TA'(TA'(in_req_i.tap_row) * TA'(MAX_KERNEL) + TA'(in_req_i.tap_col));
  end

  always_ff @(posedge clk_i) begin
    if (acc && pix_ok) begin
      line_mem[line_wa] <= pix_word;
    end
    line_rd_q <= line_mem[line_ra];
  end

  always_ff @(posedge clk_i) begin
    if (acc && is_tap && tap_ok) begin
      tap_mem[tap_wa] <= tap_word;
    end
    tap_rd_q <= tap_mem[tap_ra];
  end

  assign mac_ctrl.clr = acc && emit;
  assign mac_ctrl.vld = rd_v_q;
  assign mac_ctrl.inb = rd_inb_q;

  icv_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mac_ctrl),
    .tap_i  (tap_rd_q),
    .pix_i  (line_rd_q),
    .sum_o  (sums),
    .tot_o  (tots)
  );

  assign div_start = (state_q == ST_FLUSH) && (flush_q == 2'd0);
  // no channel normalizes when any total is zero
  assign div_norm  = norm_q && (tots[0] != '0) && (tots[1] != '0) &&
                     (tots[2] != '0) && (tots[3] != '0);

  icv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .norm_i  (div_norm),
    .sum_i   (sums),
    .tot_i   (tots),
    .done_o  (div_done),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      norm_q      <= 1'b0;
      iw_q        <= 11'd640;
      ih_q        <= 13'd480;
      kw_q        <= 3'd3;
      kh_q        <= 3'd3;
      in_row_q    <= '0;
      in_col_q    <= '0;
      in_slot_q   <= '0;
      pix_q       <= '0;
      orow_q      <= '0;
      ocol_q      <= '0;
      oslot_q     <= '0;
      ki_q        <= '0;
      kj_q        <= '0;
      flush_q     <= '0;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_v_q <= (state_q == ST_SWEEP);
      // in ST_OUT the output register is reloaded below instead
      if (out_valid_q && out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (acc && emit) begin
            state_q <= ST_SWEEP;
            ki_q    <= '0;
            kj_q    <= '0;
          end
          if (cfg_we_i) begin
            case (cfg_idx_i)
              icv_pkg::CFG_NORM: norm_q <= cfg_wdata_i[0];
              icv_pkg::CFG_IW:   iw_q   <= cfg_wdata_i[10:0];
              icv_pkg::CFG_IH:   ih_q   <= cfg_wdata_i[12:0];
              icv_pkg::CFG_KW:   kw_q   <= cfg_wdata_i[2:0];
              icv_pkg::CFG_KH:   kh_q   <= cfg_wdata_i[2:0];
              default: ;
            endcase
          end
          if (cfg_we_i && (cfg_idx_i inside {icv_pkg::CFG_NORM, icv_pkg::CFG_IW,
                                             icv_pkg::CFG_IH, icv_pkg::CFG_KW,
                                             icv_pkg::CFG_KH})) begin
            in_row_q  <= '0;
            in_col_q  <= '0;
            in_slot_q <= '0;
            pix_q     <= '0;
            orow_q    <= '0;
            ocol_q    <= '0;
            oslot_q   <= '0;
          end else if (acc && emit && last) begin
            in_row_q  <= '0;
            in_col_q  <= '0;
            in_slot_q <= '0;
            pix_q     <= '0;
            orow_q    <= '0;
            ocol_q    <= '0;
            oslot_q   <= '0;
          end else if (acc) begin
            if (pix_ok) begin
              pix_q <= pix_q + PW'(1);
              if (in_col_q == w - CW'(1)) begin
                in_col_q  <= '0;
                in_row_q  <= in_row_q + RW'(1);
                in_slot_q <= (in_slot_q == SW'(SLOTS - 1)) ? '0 : in_slot_q + SW'(1);
              end else begin
                in_col_q <= in_col_q + CW'(1);
              end
            end
            if (emit) begin
              if (ocol_q == w - CW'(1)) begin
                ocol_q  <= '0;
                orow_q  <= orow_q + RW'(1);
                oslot_q <= (oslot_q == SW'(SLOTS - 1)) ? '0 : oslot_q + SW'(1);
              end else begin
                ocol_q <= ocol_q + CW'(1);
              end
            end
          end
        end
        ST_SWEEP: begin
          if (kj_q == kw - KCW'(1)) begin
            kj_q <= '0;
            if (ki_q == kh - KCW'(1)) begin
              state_q <= ST_FLUSH;
              flush_q <= 2'd2;
            end else begin
              ki_q <= ki_q + KCW'(1);
            end
          end else begin
            kj_q <= kj_q + KCW'(1);
          end
        end
        ST_FLUSH: begin
          if (flush_q == 2'd0) begin
            state_q <= ST_DIV;
          end else begin
            flush_q <= flush_q - 2'd1;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q         <= 1'b1;
            out_q.out_red       <= res[0];
            out_q.out_green     <= res[1];
            out_q.out_blue      <= res[2];
            out_q.out_alpha     <= res[3];
            out_q.out_row       <= 12'(ei_q);
            out_q.out_col       <= 10'(ej_q);
            out_q.last_of_frame <= elast_q;
            state_q             <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // emit context and read tags
  always_ff @(posedge clk_i) begin
    if (acc && emit) begin
      ei_q    <= orow_q;
      ej_q    <= ocol_q;
      eslot_q <= oslot_q;
      elast_q <= last;
    end
    rd_inb_q <= inb;
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench of the streaming 2d convolution core. A behavioral
// predictor follows each accepted request (tap loads, pixels, drains) and
// queues the filtered pixel it should produce. Every output is compared
// field by field. Random bursts on the request side, random stalls on the
// output side, several register settings including the extremes.
// ----------------------------------------------------------------------------
module tb;

  localparam int LIM_CYCLES = 4000000;
  localparam int SLOTS      = 6;
  localparam int PW         = 1024;
  localparam int PK         = 5;
  localparam int SETTLE     = 120;
  localparam int REQ_BITS   = $bits(icv_pkg::in_req_t);
  // unused request code, handled like a drain
  localparam logic [1:0] REQ_SPARE = 2'd3;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          in_valid_i = 1'b0;
  logic                          in_ready_o;
  icv_pkg::in_req_t              in_req_i = '0;
  logic                          out_valid_o;
  logic                          out_ready_i = 1'b0;
  icv_pkg::out_res_t             out_res_o;
  logic                          cfg_we_i = 1'b0;
  logic [icv_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [icv_pkg::CFG_W-1:0]     cfg_wdata_i = '0;

  image_convolution_2d_core dut (.*);

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [15:0] line_mem [SLOTS][PW][4];
  int          tap_mem  [PK][PK][4];
  int unsigned row_in, col_in, row_out, col_out;
  int unsigned norm_reg, width_reg, height_reg, kw_reg, kh_reg;
  icv_pkg::out_res_t pixel_q[$];

  int errors = 0;
  int sent = 0;
  int burst_left = 0;
  int ready_pct = 100;
  longint cycles = 0;

  function automatic int unsigned clampdim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic logic [15:0] finish_ch(longint s, int t, bit nrm);
    longint q, ms, mt;
    if (nrm) begin
      if (s == 0) return 16'd0;
      if ((s < 0) != (t < 0)) return 16'd0;
      ms = (s < 0) ? -s : s;
      mt = (t < 0) ? -longint'(t) : longint'(t);
      q = ms / mt;
    end else begin
      if (s < 0) return 16'd0;
      q = s >>> icv_pkg::WEIGHT_FRAC_BITS;
    end
    return (q > 65535) ? 16'hffff : q[15:0];
  endfunction

  function automatic void frame_restart();
    row_in = 0; col_in = 0; row_out = 0; col_out = 0;
  endfunction

  function automatic void emit_pixel(int w, int h, int kw, int kh);
    longint   s[4];
    int       t[4];
    bit       nrm;
    int       y, x;
    bit       lst;
    icv_pkg::out_res_t o;
    nrm = (norm_reg != 0);
    for (int c = 0; c < 4; c++) begin
      s[c] = 0; t[c] = 0;
    end
    for (int ki = 0; ki < kh; ki++)
      for (int kj = 0; kj < kw; kj++)
        for (int c = 0; c < 4; c++) t[c] += tap_mem[ki][kj][c];
    for (int c = 0; c < 4; c++) if (t[c] == 0) nrm = 0;
    for (int ki = 0; ki < kh; ki++) begin
      y = int'(row_out) + ki - kh / 2;
      if (y < 0 || y >= h) continue;
      for (int kj = 0; kj < kw; kj++) begin
        x = int'(col_out) + kj - kw / 2;
        if (x < 0 || x >= w) continue;
        for (int c = 0; c < 4; c++)
          s[c] += longint'(tap_mem[ki][kj][c]) * longint'(line_mem[y % SLOTS][x][c]);
      end
    end
    o.out_red   = finish_ch(s[0], t[0], nrm);
    o.out_green = finish_ch(s[1], t[1], nrm);
    o.out_blue  = finish_ch(s[2], t[2], nrm);
    o.out_alpha = finish_ch(s[3], t[3], nrm);
    o.out_row   = row_out[11:0];
    o.out_col   = col_out[9:0];
    lst = (row_out == h - 1) && (col_out == w - 1);
    o.last_of_frame = lst;
    pixel_q = {pixel_q, o};
    if (lst) frame_restart();
    else if (++col_out >= w) begin
      col_out = 0;
      row_out++;
    end
  endfunction

  function automatic void predict_req(icv_pkg::in_req_t r);
    int unsigned w, h, kw, kh, p, lag;
    bit done;
    w = clampdim(width_reg, PW);
    h = clampdim(height_reg, icv_pkg::MAX_HEIGHT);
    kw = clampdim(kw_reg, PK);
    kh = clampdim(kh_reg, PK);
    done = (row_in >= h);
    if (r.req_type == icv_pkg::REQ_TAP) begin
      if (r.tap_row < PK && r.tap_col < PK) begin
        tap_mem[r.tap_row][r.tap_col][0] = int'(r.weight_red);
        tap_mem[r.tap_row][r.tap_col][1] = int'(r.weight_green);
        tap_mem[r.tap_row][r.tap_col][2] = int'(r.weight_blue);
        tap_mem[r.tap_row][r.tap_col][3] = int'(r.weight_alpha);
      end
    end else if (r.req_type == icv_pkg::REQ_PIX && !done && col_in < w) begin
      p = row_in * w + col_in;
      lag = (kh - 1 - kh / 2) * w + (kw - 1 - kw / 2);
      line_mem[row_in % SLOTS][col_in][0] = r.pix_red;
      line_mem[row_in % SLOTS][col_in][1] = r.pix_green;
      line_mem[row_in % SLOTS][col_in][2] = r.pix_blue;
      line_mem[row_in % SLOTS][col_in][3] = r.pix_alpha;
      if (++col_in >= w) begin
        col_in = 0;
        row_in++;
      end
      if (p >= lag) emit_pixel(w, h, kw, kh);
    end else if (done && row_out < h) begin
      emit_pixel(w, h, kw, kh);
    end
  endfunction

  // a frame still owes output once all its pixels are in
  function automatic bit frame_draining();
    return row_in >= clampdim(height_reg, icv_pkg::MAX_HEIGHT) &&
           row_out < clampdim(height_reg, icv_pkg::MAX_HEIGHT);
  endfunction

  function automatic icv_pkg::in_req_t rand_req(logic [1:0] kind);
    icv_pkg::in_req_t r;
    r = REQ_BITS'({$urandom, $urandom, $urandom, $urandom, $urandom});
    r.req_type = kind;
    return r;
  endfunction

  function automatic icv_pkg::in_req_t tap_req(int row, int col, int wr, int wg, int wb,
                                               int wa);
    icv_pkg::in_req_t r;
    r = rand_req(icv_pkg::REQ_TAP);
    r.tap_row = row[2:0];
    r.tap_col = col[2:0];
    r.weight_red = wr[15:0];
    r.weight_green = wg[15:0];
    r.weight_blue = wb[15:0];
    r.weight_alpha = wa[15:0];
    return r;
  endfunction

  function automatic icv_pkg::in_req_t pix_req(int pr, int pg, int pb, int pa);
    icv_pkg::in_req_t r;
    r = rand_req(icv_pkg::REQ_PIX);
    r.pix_red = pr[15:0];
    r.pix_green = pg[15:0];
    r.pix_blue = pb[15:0];
    r.pix_alpha = pa[15:0];
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_req(icv_pkg::in_req_t r);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_req_i = r;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_req(r);
    sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic wait_idle();
    in_valid_i = 1'b0;
    while (pixel_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [icv_pkg::CFG_IDX_W-1:0] idx, int unsigned val);
    wait_idle();
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_wdata_i = val[icv_pkg::CFG_W-1:0];
    case (idx)
      icv_pkg::CFG_NORM: norm_reg = val & 1;
      icv_pkg::CFG_IW:   width_reg = val & 32'h7ff;
      icv_pkg::CFG_IH:   height_reg = val & 32'h1fff;
      icv_pkg::CFG_KW:   kw_reg = val & 7;
      icv_pkg::CFG_KH:   kh_reg = val & 7;
      default: ;
    endcase
    frame_restart();
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_frame(int unsigned nrm, int unsigned w, int unsigned h,
                           int unsigned kw, int unsigned kh);
    write_reg(icv_pkg::CFG_NORM, nrm);
    write_reg(icv_pkg::CFG_IW, w);
    write_reg(icv_pkg::CFG_IH, h);
    write_reg(icv_pkg::CFG_KW, kw);
    write_reg(icv_pkg::CFG_KH, kh);
  endtask

  task automatic drain_frame();
    while (frame_draining()) send_req(rand_req(icv_pkg::REQ_DRAIN));
  endtask

  function automatic int small_weight();
    return $urandom_range(0, 3) == 0 ? int'($urandom_range(0, 65535)) - 32768
                                     : int'($urandom_range(0, 1200)) - 200;
  endfunction

  task automatic load_all_taps(bit extreme);
    for (int rr = 0; rr < PK; rr++)
      for (int cc = 0; cc < PK; cc++)
        if (extreme)
          send_req(tap_req(rr, cc, -32768, 32767, int'($urandom_range(0, 65535)) - 32768,
                           (rr == 2 && cc == 2) ? 4096 : 0));
        else
          send_req(tap_req(rr, cc, small_weight(), small_weight(), small_weight(),
                           small_weight()));
  endtask

  task automatic test_directed();
    // identity kernel first, then extremes on some taps
    for (int rr = 0; rr < PK; rr++)
      for (int cc = 0; cc < PK; cc++)
        send_req(tap_req(rr, cc, 0, 0, 0, 0));
    send_req(tap_req(2, 2, 4096, 4096, 4096, 4096));
    send_req(tap_req(1, 1, 32767, -32768, 1, -1));
    send_req(tap_req(5, 2, 7, 7, 7, 7));   // out of range, ignored
    send_req(tap_req(2, 7, 9, 9, 9, 9));
    send_req(tap_req(7, 7, 9, 9, 9, 9));
    set_frame(0, 3, 2, 3, 3);
    send_req(pix_req(0, 0, 0, 0));
    send_req(pix_req(65535, 65535, 65535, 65535));
    send_req(rand_req(icv_pkg::REQ_DRAIN)); // early drain
    send_req(pix_req(65535, 0, 65535, 0));
    send_req(pix_req(0, 65535, 0, 65535));
    send_req(rand_req(REQ_SPARE));          // code three before frame end
    send_req(pix_req(1, 2, 3, 4));
    send_req(pix_req(65535, 65535, 65535, 65535));
    send_req(pix_req(5, 5, 5, 5));          // surplus pixel drains
    send_req(rand_req(REQ_SPARE));
    drain_frame();
    send_req(rand_req(icv_pkg::REQ_DRAIN)); // new frame, nothing owed
  endtask

  task automatic test_normalize();
    load_all_taps(0);
    set_frame(1, 4, 3, 3, 3);
    for (int k = 0; k < 12; k++)
      send_req(pix_req($urandom, $urandom, $urandom, $urandom));
    drain_frame();
    // zero total on one channel turns normalization off everywhere
    for (int rr = 0; rr < PK; rr++)
      for (int cc = 0; cc < PK; cc++)
        send_req(tap_req(rr, cc, 100, 200, 0, 300));
    set_frame(1, 3, 3, 2, 2);
    for (int k = 0; k < 9; k++)
      send_req(pix_req($urandom, $urandom, $urandom, $urandom));
    drain_frame();
    load_all_taps(1);
    set_frame(1, 2, 2, 5, 5);
    for (int k = 0; k < 4; k++)
      send_req(pix_req($urandom, $urandom, $urandom, $urandom));
    drain_frame();
  endtask

  task automatic test_large();
    load_all_taps(0);
    set_frame(0, 1024, 1, 5, 1);
    for (int k = 0; k < 1024; k++)
      send_req(pix_req($urandom, $urandom, $urandom, $urandom));
    drain_frame();
    // clamped sizes, partial frame then restart
    set_frame(1, 2047, 8191, 7, 6);
    for (int k = 0; k < 20; k++)
      send_req(pix_req($urandom, $urandom, $urandom, $urandom));
    set_frame(0, 1, 4096, 0, 5);
    for (int k = 0; k < 30; k++)
      send_req(pix_req($urandom, $urandom, $urandom, $urandom));
    set_frame(0, 0, 0, 1, 0);
    send_req(pix_req($urandom, $urandom, $urandom, $urandom));
    drain_frame();
  endtask

  task automatic test_random_frames();
    int unsigned w, h, n, cut, pick;
    while (sent < 2000) begin
      if ($urandom_range(0, 2) == 0) load_all_taps($urandom_range(0, 5) == 0);
      w = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2047) : $urandom_range(1, 7);
      h = $urandom_range(0, 9) == 0 ? $urandom_range(0, 8191) : $urandom_range(1, 5);
      if (clampdim(w, PW) > 16) h = $urandom_range(0, 1);
      set_frame($urandom_range(0, 1), w, h, $urandom_range(0, 7), $urandom_range(0, 7));
      n = clampdim(w, PW) * clampdim(h, icv_pkg::MAX_HEIGHT);
      cut = ($urandom_range(0, 4) == 0 || n > 64) ? $urandom_range(0, (n > 64) ? 64 : n) : n;
      for (int k = 0; k < cut; k++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) send_req(rand_req(icv_pkg::REQ_TAP));
        else if (pick == 1) send_req(rand_req(icv_pkg::REQ_DRAIN));
        else if (pick == 2) send_req(rand_req(REQ_SPARE));
        send_req(pix_req($urandom, $urandom, $urandom, $urandom));
      end
      if (cut == n) drain_frame();
    end
  endtask

  // output side: random stalls of changing density
  always @(negedge clk_i) begin
    if (cycles % 300 == 0) ready_pct = ($urandom_range(0, 2) == 0) ? 100 :
                                       $urandom_range(10, 90);
    out_ready_i <= ($urandom_range(1, 100) <= ready_pct);
  end

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin
    icv_pkg::out_res_t e;
    cycles++;
    if (cycles > LIM_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end else if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixel_q.size() == 0) begin
        $error("output pixel with none expected");
        errors++;
      end else begin
        e = pixel_q.pop_front();
        check_field("out_red", e.out_red, out_res_o.out_red);
        check_field("out_green", e.out_green, out_res_o.out_green);
        check_field("out_blue", e.out_blue, out_res_o.out_blue);
        check_field("out_alpha", e.out_alpha, out_res_o.out_alpha);
        check_field("out_row", e.out_row, out_res_o.out_row);
        check_field("out_col", e.out_col, out_res_o.out_col);
        check_field("last_of_frame", e.last_of_frame, out_res_o.last_of_frame);
      end
    end
  end

  initial begin
    norm_reg = 0; width_reg = 640; height_reg = 480; kw_reg = 3; kh_reg = 3;
    frame_restart();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_normalize();
    test_large();
    test_random_frames();
    wait_idle();
    if (errors == 0 && pixel_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
